// ===== rtl/core/bfpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpdd_pkg
// Shared constants and types of the binary fixed-point to decimal digits unit.
// ----------------------------------------------------------------------------
package bfpdd_pkg;

    localparam int INT_BITS   = 64;
    localparam int FRAC_BITS  = 32;
    localparam int BCD_DIGITS = 20;

    localparam int BCD_W   = 4 * BCD_DIGITS;
    localparam int ICNT_W  = $clog2(INT_BITS + 1);
    localparam int FCNT_W  = $clog2(FRAC_BITS + 1);
    localparam int FIDX_W  = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
    localparam int DCNT_W  = $clog2(BCD_DIGITS + 1);
    localparam int LIMIT_W = 7;

    localparam logic [1:0] SYM_ZERO  = 2'd0;
    localparam logic [1:0] SYM_ONE   = 2'd1;
    localparam logic [1:0] SYM_POINT = 2'd2;
    localparam logic [1:0] SYM_BAD   = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_ALL = '1;  // -1: one digit per fraction bit

    typedef enum logic [5:0] {
        ST_COLLECT = 6'b000001,
        ST_CONVERT = 6'b000010,
        ST_SKIP    = 6'b000100,
        ST_INT     = 6'b001000,
        ST_POINT   = 6'b010000,
        ST_FRAC    = 6'b100000
    } state_t;

endpackage

// ===== rtl/core/binary_fixed_point_to_decimal_digits_unit.sv =====
// ----------------------------------------------------------------------------
// binary_fixed_point_to_decimal_digits_unit
// Collects a binary numeral symbol by symbol and emits its decimal digits:
// integer part by bit-serial double dabble, fraction by repeated times ten.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, symbol, last_symbol   | in
//  output  | out_valid, out_stall, digit, is_point,    | out
//          | error, last_result                        |
//  config  | cfg_we, cfg_wdata                         | in
//
//  symbols are taken one per cycle until the last one of a numeral
//  then double dabble converts one integer bit per cycle, leading zero digits
//  are dropped, and the words go out through the output register
//  a bad numeral gives a single error word after its last symbol
//  reset clears the numeral state and sets the digit limit to -1
//  out_stall holds the output register; the sequencer waits on it
// ----------------------------------------------------------------------------
module binary_fixed_point_to_decimal_digits_unit
    import bfpdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         symbol,
    input  logic               last_symbol,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         digit,
    output logic               is_point,
    output logic               error,
    output logic               last_result,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [INT_BITS-1:0]  int_reg, int_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [ICNT_W-1:0]    icnt_reg, icnt_next;
    logic [FCNT_W-1:0]    fcnt_reg, fcnt_next;
    logic                 point_reg, point_next;
    logic                 ovf_reg, ovf_next;
    logic [ICNT_W-1:0]    conv_cnt_reg, conv_cnt_next;
    logic [DCNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    logic [LIMIT_W-1:0]   frac_left_reg, frac_left_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;

    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           digit_reg, digit_next;
    logic                 is_point_reg, is_point_next;
    logic                 error_reg, error_next;
    logic                 last_reg, last_next;

    logic                 slot_free;
    logic                 load_out;
    logic                 clear;
    logic [FIDX_W-1:0]    frac_idx;
    logic [BCD_W-1:0]     bcd_adj;
    logic [LIMIT_W-1:0]   limit_eff;
    logic                 frac_go;
    logic [FRAC_BITS+3:0] prod;

    assign in_stall  = (state_reg != ST_COLLECT);
    assign slot_free = !out_valid_reg || !out_stall;
    // first fraction bit lands at the msb, so the fraction stays left aligned
    assign frac_idx  = FIDX_W'(FRAC_BITS - 1) - fcnt_reg[FIDX_W-1:0];

    assign limit_eff = (limit_reg == LIMIT_ALL) ? LIMIT_W'(fcnt_reg) : limit_reg;
    assign frac_go   = (frac_reg != '0) && !limit_eff[LIMIT_W-1] && (limit_eff != '0);
    assign prod      = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);

    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            bcd_adj[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ? bcd_reg[d*4 +: 4] + 4'd3
                                                            : bcd_reg[d*4 +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        icnt_next      = icnt_reg;
        fcnt_next      = fcnt_reg;
        point_next     = point_reg;
        ovf_next       = ovf_reg;
        conv_cnt_next  = conv_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        frac_left_next = frac_left_reg;
        bcd_next       = bcd_reg;
        load_out       = 1'b0;
        clear          = 1'b0;
        digit_next     = 4'd0;
        is_point_next  = 1'b0;
        error_next     = 1'b0;
        last_next      = 1'b0;

        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    case (symbol)
                        SYM_POINT:
                        begin
                            if (point_reg)
                            begin
                                ovf_next = 1'b1;
                            end
                            point_next = 1'b1;
                        end
                        SYM_BAD:
                        begin
                            ovf_next = 1'b1;
                        end
                        default:
                        begin
                            if (point_reg)
                            begin
                                if (fcnt_reg >= FCNT_W'(FRAC_BITS))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    frac_next[frac_idx] = symbol[0];
                                    fcnt_next           = fcnt_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                if (icnt_reg >= ICNT_W'(INT_BITS))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    int_next  = {int_reg[INT_BITS-2:0], symbol[0]};
                                    icnt_next = icnt_reg + 1'b1;
                                end
                            end
                        end
                    endcase

                    if (last_symbol)
                    begin
                        if (ovf_next)
                        begin
                            // error word goes out through the point state, in place of the point
                            state_next = ST_POINT;
                        end
                        else
                        begin
                            bcd_next      = '0;
                            conv_cnt_next = ICNT_W'(INT_BITS);
                            state_next    = ST_CONVERT;
                        end
                    end
                end
            end
            ST_CONVERT:
            begin
                bcd_next      = {bcd_adj[BCD_W-2:0], int_reg[INT_BITS-1]};
                int_next      = {int_reg[INT_BITS-2:0], 1'b0};
                conv_cnt_next = conv_cnt_reg - 1'b1;
                if (conv_cnt_reg == ICNT_W'(1))
                begin
                    dig_cnt_next = DCNT_W'(BCD_DIGITS);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if ((bcd_reg[BCD_W-1 -: 4] == 4'd0) && (dig_cnt_reg > DCNT_W'(1)))
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                if (slot_free)
                begin
                    load_out     = 1'b1;
                    digit_next   = bcd_reg[BCD_W-1 -: 4];
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DCNT_W'(1))
                    begin
                        if (frac_go)
                        begin
                            frac_left_next = limit_eff;
                            state_next     = ST_POINT;
                        end
                        else
                        begin
                            last_next  = 1'b1;
                            clear      = 1'b1;
                            state_next = ST_COLLECT;
                        end
                    end
                end
            end
            ST_POINT:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (ovf_reg)
                    begin
                        error_next = 1'b1;
                        last_next  = 1'b1;
                        clear      = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        is_point_next = 1'b1;
                        state_next    = ST_FRAC;
                    end
                end
            end
            ST_FRAC:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    digit_next     = prod[FRAC_BITS+3:FRAC_BITS];
                    frac_next      = prod[FRAC_BITS-1:0];
                    frac_left_next = frac_left_reg - 1'b1;
                    if ((prod[FRAC_BITS-1:0] == '0) || (frac_left_reg == LIMIT_W'(1)))
                    begin
                        last_next  = 1'b1;
                        clear      = 1'b1;
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase

        if (clear)
        begin
            int_next   = '0;
            frac_next  = '0;
            icnt_next  = '0;
            fcnt_next  = '0;
            point_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            limit_reg     <= LIMIT_ALL;
            int_reg       <= '0;
            frac_reg      <= '0;
            icnt_reg      <= '0;
            fcnt_reg      <= '0;
            point_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            conv_cnt_reg  <= '0;
            dig_cnt_reg   <= '0;
            frac_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            icnt_reg      <= icnt_next;
            fcnt_reg      <= fcnt_next;
            point_reg     <= point_next;
            ovf_reg       <= ovf_next;
            conv_cnt_reg  <= conv_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            frac_left_reg <= frac_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        if (load_out)
        begin
            digit_reg    <= digit_next;
            is_point_reg <= is_point_next;
            error_reg    <= error_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit       = digit_reg;
    assign is_point    = is_point_reg;
    assign error       = error_reg;
    assign last_result = last_reg;

    // an error word stands alone and carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (last_result && !is_point && (digit == 4'd0)))
    else $error("error word with stray fields");

    // a point is always followed by at least one fraction digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_point) |-> (!last_result && (digit == 4'd0)))
    else $error("point word closes numeral or carries a digit");

    // every digit word is a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit <= 4'd9))
    else $error("digit out of decimal range");

    // no new symbols are taken while the previous numeral is converted
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_symbol) |=> in_stall)
    else $error("symbol taken during conversion");

endmodule
